// ----- src/usb_standard_request_handler_macros.svh -----
// assertion macros for the usb standard request handler
// used only by the top level, needs clock and reset in scope
`ifndef USB_STANDARD_REQUEST_HANDLER_MACROS_SVH
`define USB_STANDARD_REQUEST_HANDLER_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define USR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define USR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/usr_pkg.sv -----
// shared types, codes and constants of the usb standard request handler
// no dependencies; used by every module of the block
package usr_pkg;

   // default number of endpoints with a halt bit
   localparam int MAX_ENDPOINTS_DEF = 8;
   // endpoint select width, covers up to sixteen endpoints
   localparam int EP_SEL_W = 4;

   // event codes on the action field
   localparam logic [1:0] ACT_BUS_RESET = 2'd0;
   localparam logic [1:0] ACT_SETUP     = 2'd1;
   localparam logic [1:0] ACT_STATUS    = 2'd2;

   // response codes
   localparam logic [2:0] RSP_NONE  = 3'd0;
   localparam logic [2:0] RSP_ACK   = 3'd1;
   localparam logic [2:0] RSP_DATA  = 3'd2;
   localparam logic [2:0] RSP_STALL = 3'd3;
   localparam logic [2:0] RSP_CLASS = 3'd4;
   localparam logic [2:0] RSP_DESC  = 3'd5;
   localparam logic [2:0] RSP_ADDR  = 3'd6;

   // device phase codes
   localparam logic [1:0] PH_DEFAULT    = 2'd0;
   localparam logic [1:0] PH_ADDRESSED  = 2'd1;
   localparam logic [1:0] PH_CONFIGURED = 2'd2;

   // bmRequestType fields
   localparam logic [7:0] TYPE_MASK   = 8'h60;
   localparam logic [7:0] RECIP_MASK  = 8'h0F;
   localparam logic [3:0] RCP_DEVICE    = 4'd0;
   localparam logic [3:0] RCP_INTERFACE = 4'd1;
   localparam logic [3:0] RCP_ENDPOINT  = 4'd2;

   // standard request codes
   localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
   localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
   localparam logic [7:0] REQ_SET_FEATURE   = 8'h03;
   localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
   localparam logic [7:0] REQ_GET_DESC      = 8'h06;
   localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
   localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
   localparam logic [7:0] REQ_GET_INTERFACE = 8'h0A;
   localparam logic [7:0] REQ_SET_INTERFACE = 8'h0B;
   localparam logic [7:0] NO_REQUEST        = 8'hFF;

   // configuration register indexes
   localparam logic [1:0] CSR_SELF_POWERED    = 2'd0;
   localparam logic [1:0] CSR_ENDPOINTS_USED  = 2'd1;
   localparam logic [1:0] CSR_INTERFACES_USED = 2'd2;

   // configuration register reset values
   localparam logic [3:0] ENDPOINTS_USED_RST  = 4'd8;
   localparam logic [7:0] INTERFACES_USED_RST = 8'd1;

   // device state apart from the halt bits
   typedef struct packed {
      logic [1:0] phase;
      logic       config_sel;
      logic [7:0] last_request;
      logic [6:0] pending_address;
      logic [6:0] current_address;
   } state_type;

   // halt bit update from the decoder
   typedef struct packed {
      logic                clear_all;
      logic                write;
      logic                value;
      logic [EP_SEL_W-1:0] select;
   } halt_upd_type;

   // per-request answer, apart from the state echo
   typedef struct packed {
      logic [2:0] response;
      logic [1:0] reply_length;
      logic [7:0] reply_first;
      logic [7:0] reply_second;
      logic       toggles_reset;
      logic       interface_reset;
      logic [7:0] reset_interface;
      logic [7:0] reset_alternate;
   } answer_type;

endpackage

// ----- src/usb_standard_request_handler.sv -----
// top level of the usb standard request handler: input register, decoder, result register
// depends on usr_pkg, usr_decode, usr_state and usb_standard_request_handler_macros.svh
//
//   channel | direction | handshake        | contents
//   req_    | in        | valid / stall    | action and setup packet fields
//   rsp_    | out       | valid / stall    | response, reply bytes, device status
//   csr_    | in        | write enable     | self powered, endpoint and interface counts
//
// one request per cycle while rsp_ is not stalled; a request passes through the input register
// and then the result register before it appears on rsp_.
// device state updates as a request leaves the input register, so the next
// request already sees it. synchronous reset clears state, configuration registers and valids.
// a stalled result holds the input register, which then stalls req_.
module usb_standard_request_handler #(
   parameter int MaxEndpoints = usr_pkg::MAX_ENDPOINTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_request_type,
   input  logic [7:0]  req_request_code,
   input  logic [15:0] req_request_value,
   input  logic [15:0] req_request_index,
   input  logic [15:0] req_request_length,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_response,
   output logic [1:0]  rsp_reply_length,
   output logic [7:0]  rsp_reply_first,
   output logic [7:0]  rsp_reply_second,
   output logic [6:0]  rsp_device_address,
   output logic        rsp_active_config,
   output logic        rsp_configured,
   output logic        rsp_toggles_reset,
   output logic        rsp_interface_reset,
   output logic [7:0]  rsp_reset_interface,
   output logic [7:0]  rsp_reset_alternate,
   // configuration port
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data
);

   `include "usb_standard_request_handler_macros.svh"

   logic        self_powered_ff;
   logic [3:0]  endpoints_used_ff;
   logic [7:0]  interfaces_used_ff;

   logic        in_valid_ff;
   logic [1:0]  in_action_ff;
   logic [7:0]  in_type_ff;
   logic [7:0]  in_code_ff;
   logic [15:0] in_value_ff;
   logic [15:0] in_index_ff;

   logic        out_free;
   logic        advance;
   logic        req_take;

   usr_pkg::state_type      state;
   usr_pkg::state_type      state_in;
   usr_pkg::halt_upd_type   halt_upd;
   usr_pkg::answer_type     answer;
   logic [MaxEndpoints-1:0] halt;

   logic                rsp_valid_ff;
   usr_pkg::answer_type answer_ff;
   logic [6:0]          address_ff;
   logic                config_ff;
   logic                configured_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         self_powered_ff    <= 1'b0;
         endpoints_used_ff  <= usr_pkg::ENDPOINTS_USED_RST;
         interfaces_used_ff <= usr_pkg::INTERFACES_USED_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            usr_pkg::CSR_SELF_POWERED:    self_powered_ff    <= csr_write_data[0];
            usr_pkg::CSR_ENDPOINTS_USED:  endpoints_used_ff  <= csr_write_data[3:0];
            usr_pkg::CSR_INTERFACES_USED: interfaces_used_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // handshake between the two stages
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // input register; wLength is only meaningful to the class logic
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_action;
         in_type_ff   <= req_request_type;
         in_code_ff   <= req_request_code;
         in_value_ff  <= req_request_value;
         in_index_ff  <= req_request_index;
      end
   end

   // request decoder
   usr_decode #(
      .MaxEndpoints(MaxEndpoints)
   ) u_decode (
      .action          (in_action_ff),
      .request_type    (in_type_ff),
      .request_code    (in_code_ff),
      .request_value   (in_value_ff),
      .request_index   (in_index_ff),
      .self_powered    (self_powered_ff),
      .endpoints_used  (endpoints_used_ff),
      .interfaces_used (interfaces_used_ff),
      .state           (state),
      .halt            (halt),
      .state_next      (state_in),
      .halt_upd        (halt_upd),
      .answer          (answer)
   );

   // device state
   usr_state #(
      .MaxEndpoints(MaxEndpoints)
   ) u_state (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .state_in (state_in),
      .halt_upd (halt_upd),
      .state    (state),
      .halt     (halt)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         answer_ff     <= answer;
         address_ff    <= state_in.current_address;
         config_ff     <= state_in.config_sel;
         configured_ff <= (state_in.phase == usr_pkg::PH_CONFIGURED);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_response        = answer_ff.response;
   assign rsp_reply_length    = answer_ff.reply_length;
   assign rsp_reply_first     = answer_ff.reply_first;
   assign rsp_reply_second    = answer_ff.reply_second;
   assign rsp_device_address  = address_ff;
   assign rsp_active_config   = config_ff;
   assign rsp_configured      = configured_ff;
   assign rsp_toggles_reset   = answer_ff.toggles_reset;
   assign rsp_interface_reset = answer_ff.interface_reset;
   assign rsp_reset_interface = answer_ff.reset_interface;
   assign rsp_reset_alternate = answer_ff.reset_alternate;

   // checks
   `USR_ASSERT_NEXT(a_advance_loads, advance, rsp_valid_ff, "result register not loaded")
   `USR_ASSERT_NOW(a_cfg_match, rsp_valid_ff, configured_ff == config_ff, "configured and configuration disagree")
   `USR_ASSERT_NOW(a_len_data, rsp_valid_ff && answer_ff.reply_length != 2'd0, answer_ff.response == usr_pkg::RSP_DATA, "reply bytes without data response")
   `USR_ASSERT_NOW(a_toggle_cfg, rsp_valid_ff && answer_ff.toggles_reset, configured_ff && answer_ff.response == usr_pkg::RSP_ACK, "toggle reset outside configured ack")

endmodule

// ----- src/usr_decode.sv -----
// request decoder: next device state, halt update and answer for one request
// depends on usr_pkg
module usr_decode #(
   parameter int MaxEndpoints = usr_pkg::MAX_ENDPOINTS_DEF
) (
   input  logic [1:0]              action,
   input  logic [7:0]              request_type,
   input  logic [7:0]              request_code,
   input  logic [15:0]             request_value,
   input  logic [15:0]             request_index,
   input  logic                    self_powered,
   input  logic [3:0]              endpoints_used,
   input  logic [7:0]              interfaces_used,
   input  usr_pkg::state_type      state,
   input  logic [MaxEndpoints-1:0] halt,
   output usr_pkg::state_type      state_next,
   output usr_pkg::halt_upd_type   halt_upd,
   output usr_pkg::answer_type     answer
);

   logic [3:0] recip;
   logic       addr_or_cfg;
   logic       if_ok;
   logic       ep_ok;
   logic       halt_bit;

   // qualifiers for the recipient branches
   always_comb begin
      recip       = 4'(request_type & usr_pkg::RECIP_MASK);
      addr_or_cfg = (state.phase == usr_pkg::PH_ADDRESSED) ||
                    (state.phase == usr_pkg::PH_CONFIGURED);
      if_ok       = (state.phase == usr_pkg::PH_CONFIGURED) &&
                    (request_index < {8'd0, interfaces_used});
      ep_ok       = ((state.phase == usr_pkg::PH_CONFIGURED) ||
                     (state.phase == usr_pkg::PH_ADDRESSED && request_index == 16'd0)) &&
                    (request_index < {12'd0, endpoints_used}) &&
                    (request_index < 16'(MaxEndpoints)) &&
                    (request_value == 16'd0);
   end

   // halt bit of the addressed endpoint
   always_comb begin
      halt_bit = 1'b0;
      for (int i = 0; i < MaxEndpoints; i++) begin
         if (request_index[usr_pkg::EP_SEL_W-1:0] == usr_pkg::EP_SEL_W'(i)) begin
            halt_bit = halt[i];
         end
      end
   end

   // main decision
   always_comb begin
      state_next = state;
      halt_upd   = '0;
      answer     = '0;
      halt_upd.select = request_index[usr_pkg::EP_SEL_W-1:0];
      case (action)
         usr_pkg::ACT_BUS_RESET: begin
            state_next         = '0;
            halt_upd.clear_all = 1'b1;
         end
         usr_pkg::ACT_STATUS: begin
            // address takes effect only after the set address status stage
            if (state.last_request == usr_pkg::REQ_SET_ADDRESS) begin
               state_next.current_address = state.pending_address;
               answer.response            = usr_pkg::RSP_ADDR;
            end
         end
         usr_pkg::ACT_SETUP: begin
            if ((request_type & usr_pkg::TYPE_MASK) != 8'd0) begin
               answer.response = usr_pkg::RSP_CLASS;
            end else if (recip == usr_pkg::RCP_DEVICE) begin
               case (request_code)
                  usr_pkg::REQ_GET_STATUS: begin
                     answer.response     = usr_pkg::RSP_DATA;
                     answer.reply_length = 2'd2;
                     answer.reply_first  = {7'd0, self_powered};
                  end
                  usr_pkg::REQ_SET_FEATURE: begin
                     answer.response = usr_pkg::RSP_ACK;
                  end
                  usr_pkg::REQ_SET_ADDRESS: begin
                     if (state.phase == usr_pkg::PH_DEFAULT ||
                         state.phase == usr_pkg::PH_ADDRESSED) begin
                        answer.response            = usr_pkg::RSP_ACK;
                        state_next.phase           = usr_pkg::PH_ADDRESSED;
                        state_next.pending_address = request_value[6:0];
                     end else begin
                        answer.response = usr_pkg::RSP_STALL;
                     end
                  end
                  usr_pkg::REQ_GET_DESC: begin
                     answer.response = usr_pkg::RSP_DESC;
                  end
                  usr_pkg::REQ_GET_CONFIG: begin
                     if (addr_or_cfg) begin
                        // addressed state always reports configuration zero
                        if (state.phase == usr_pkg::PH_ADDRESSED) begin
                           state_next.config_sel = 1'b0;
                        end
                        answer.response     = usr_pkg::RSP_DATA;
                        answer.reply_length = 2'd1;
                        answer.reply_first  = {7'd0, state_next.config_sel};
                     end else begin
                        answer.response = usr_pkg::RSP_STALL;
                     end
                  end
                  usr_pkg::REQ_SET_CONFIG: begin
                     if (addr_or_cfg && request_value[7:0] == 8'd0) begin
                        state_next.phase      = usr_pkg::PH_ADDRESSED;
                        state_next.config_sel = 1'b0;
                        answer.response       = usr_pkg::RSP_ACK;
                     end else if (addr_or_cfg && request_value[7:0] == 8'd1) begin
                        state_next.phase      = usr_pkg::PH_CONFIGURED;
                        state_next.config_sel = 1'b1;
                        answer.response       = usr_pkg::RSP_ACK;
                        answer.toggles_reset  = 1'b1;
                     end else begin
                        answer.response = usr_pkg::RSP_STALL;
                     end
                  end
                  default: begin
                     answer.response = usr_pkg::RSP_STALL;
                  end
               endcase
            end else if (recip == usr_pkg::RCP_INTERFACE) begin
               if (request_code == usr_pkg::REQ_GET_STATUS &&
                   state.phase == usr_pkg::PH_CONFIGURED) begin
                  answer.response     = usr_pkg::RSP_DATA;
                  answer.reply_length = 2'd2;
               end else if (request_code == usr_pkg::REQ_GET_INTERFACE && if_ok) begin
                  answer.response     = usr_pkg::RSP_DATA;
                  answer.reply_length = 2'd1;
               end else if (request_code == usr_pkg::REQ_SET_INTERFACE && if_ok) begin
                  answer.response        = usr_pkg::RSP_ACK;
                  answer.interface_reset = 1'b1;
                  answer.reset_interface = request_index[7:0];
                  answer.reset_alternate = request_value[7:0];
               end else begin
                  answer.response = usr_pkg::RSP_STALL;
               end
            end else if (recip == usr_pkg::RCP_ENDPOINT) begin
               if (!ep_ok || (request_code != usr_pkg::REQ_GET_STATUS &&
                              request_code != usr_pkg::REQ_CLEAR_FEATURE &&
                              request_code != usr_pkg::REQ_SET_FEATURE)) begin
                  answer.response = usr_pkg::RSP_STALL;
               end else if (request_code == usr_pkg::REQ_GET_STATUS) begin
                  answer.response     = usr_pkg::RSP_DATA;
                  answer.reply_length = 2'd2;
                  answer.reply_first  = {7'd0, halt_bit};
               end else begin
                  halt_upd.write  = 1'b1;
                  halt_upd.value  = (request_code == usr_pkg::REQ_SET_FEATURE);
                  answer.response = usr_pkg::RSP_ACK;
               end
            end else begin
               answer.response = usr_pkg::RSP_STALL;
            end
            // remember accepted requests for the status stage
            if (answer.response == usr_pkg::RSP_ACK || answer.response == usr_pkg::RSP_DATA) begin
               state_next.last_request = request_code;
            end else begin
               state_next.last_request = usr_pkg::NO_REQUEST;
            end
         end
         default: begin
            state_next = state;
         end
      endcase
   end

endmodule

// ----- src/usr_state.sv -----
// device state registers and per-endpoint halt bits
// depends on usr_pkg; loaded from usr_decode when a request moves to the result stage
module usr_state #(
   parameter int MaxEndpoints = usr_pkg::MAX_ENDPOINTS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  usr_pkg::state_type      state_in,
   input  usr_pkg::halt_upd_type   halt_upd,
   output usr_pkg::state_type      state,
   output logic [MaxEndpoints-1:0] halt
);

   usr_pkg::state_type      state_ff;
   logic [MaxEndpoints-1:0] halt_ff;
   logic [MaxEndpoints-1:0] halt_in;

   // next halt vector
   always_comb begin
      halt_in = halt_ff;
      if (halt_upd.clear_all) begin
         halt_in = '0;
      end else if (halt_upd.write) begin
         for (int i = 0; i < MaxEndpoints; i++) begin
            if (halt_upd.select == usr_pkg::EP_SEL_W'(i)) begin
               halt_in[i] = halt_upd.value;
            end
         end
      end
   end

   // state update per request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         halt_ff  <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         halt_ff  <= halt_in;
      end
   end

   assign state = state_ff;
   assign halt  = halt_ff;

endmodule

// ----- dv/usr_reply_checker.sv -----
// result checker for the usb standard request handler: predicts each result and compares
// depends on usr_pkg; watches the req_, rsp_ and csr_ ports beside the block
module usr_reply_checker
   import usr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_request_type,
   input  logic [7:0]  req_request_code,
   input  logic [15:0] req_request_value,
   input  logic [15:0] req_request_index,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_response,
   input  logic [1:0]  rsp_reply_length,
   input  logic [7:0]  rsp_reply_first,
   input  logic [7:0]  rsp_reply_second,
   input  logic [6:0]  rsp_device_address,
   input  logic        rsp_active_config,
   input  logic        rsp_configured,
   input  logic        rsp_toggles_reset,
   input  logic        rsp_interface_reset,
   input  logic [7:0]  rsp_reset_interface,
   input  logic [7:0]  rsp_reset_alternate,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data,
   output int          mismatches,
   output int          replies_pending,
   output int          replies_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   // one result of the block, field by field
   typedef struct packed {
      logic [2:0] response;
      logic [1:0] reply_length;
      logic [7:0] reply_first;
      logic [7:0] reply_second;
      logic [6:0] device_address;
      logic       active_config;
      logic       configured;
      logic       toggles_reset;
      logic       interface_reset;
      logic [7:0] reset_interface;
      logic [7:0] reset_alternate;
   } usb_reply_t;

   usb_reply_t expected_replies[$];

   // predicted device state
   logic [1:0]                   phase;
   logic                         cfg_sel;
   logic [MAX_ENDPOINTS_DEF-1:0] halt;
   logic [7:0]                   last_req;
   logic [6:0]                   pend_addr;
   logic [6:0]                   cur_addr;

   // predicted register copies
   logic       self_pow;
   logic [3:0] ep_count;
   logic [7:0] if_count;

   int fails = 0;
   int seen = 0;
   assign mismatches = fails;
   assign replies_checked = seen;
   assign replies_pending = expected_replies.size();

   function automatic void clear_device();
      phase     = PH_DEFAULT;
      cfg_sel   = 1'b0;
      halt      = '0;
      last_req  = 8'd0;
      pend_addr = 7'd0;
      cur_addr  = 7'd0;
   endfunction

   // next result of the device for one request, updating the predicted state
   function automatic usb_reply_t predict_reply(input logic [1:0] act, input logic [7:0] rtype,
                                                input logic [7:0] code, input logic [15:0] value,
                                                input logic [15:0] index);
      usb_reply_t r;
      logic [3:0] recip;
      logic       addr_or_cfg;
      logic       if_ok;
      logic       ep_ok;
      r = '0;
      recip = 4'(rtype & RECIP_MASK);
      addr_or_cfg = (phase == PH_ADDRESSED) || (phase == PH_CONFIGURED);
      if_ok = (phase == PH_CONFIGURED) && (index < 16'(if_count));
      ep_ok = ((phase == PH_CONFIGURED) || (phase == PH_ADDRESSED && index == 16'd0))
              && (index < 16'(ep_count)) && (index < MAX_ENDPOINTS_DEF) && (value == 16'd0);
      case (act)
         ACT_BUS_RESET: begin
            clear_device();
         end
         ACT_STATUS: begin
            // the held address takes effect only after an accepted set address
            if (last_req == REQ_SET_ADDRESS) begin
               cur_addr = pend_addr;
               r.response = RSP_ADDR;
            end
         end
         ACT_SETUP: begin
            if ((rtype & TYPE_MASK) != 8'd0) begin
               r.response = RSP_CLASS;
            end else if (recip == RCP_DEVICE) begin
               case (code)
                  REQ_GET_STATUS: begin
                     r.response = RSP_DATA;
                     r.reply_length = 2'd2;
                     r.reply_first = {7'd0, self_pow};
                  end
                  REQ_SET_FEATURE: r.response = RSP_ACK;
                  REQ_SET_ADDRESS: begin
                     if (phase == PH_DEFAULT || phase == PH_ADDRESSED) begin
                        r.response = RSP_ACK;
                        phase = PH_ADDRESSED;
                        pend_addr = value[6:0];
                     end else begin
                        r.response = RSP_STALL;
                     end
                  end
                  REQ_GET_DESC: r.response = RSP_DESC;
                  REQ_GET_CONFIG: begin
                     if (addr_or_cfg) begin
                        if (phase == PH_ADDRESSED) cfg_sel = 1'b0;
                        r.response = RSP_DATA;
                        r.reply_length = 2'd1;
                        r.reply_first = {7'd0, cfg_sel};
                     end else begin
                        r.response = RSP_STALL;
                     end
                  end
                  REQ_SET_CONFIG: begin
                     if (addr_or_cfg && value[7:0] == 8'd0) begin
                        phase = PH_ADDRESSED;
                        cfg_sel = 1'b0;
                        r.response = RSP_ACK;
                     end else if (addr_or_cfg && value[7:0] == 8'd1) begin
                        phase = PH_CONFIGURED;
                        cfg_sel = 1'b1;
                        r.response = RSP_ACK;
                        r.toggles_reset = 1'b1;
                     end else begin
                        r.response = RSP_STALL;
                     end
                  end
                  default: r.response = RSP_STALL;
               endcase
            end else if (recip == RCP_INTERFACE) begin
               if (code == REQ_GET_STATUS && phase == PH_CONFIGURED) begin
                  r.response = RSP_DATA;
                  r.reply_length = 2'd2;
               end else if (code == REQ_GET_INTERFACE && if_ok) begin
                  r.response = RSP_DATA;
                  r.reply_length = 2'd1;
               end else if (code == REQ_SET_INTERFACE && if_ok) begin
                  r.response = RSP_ACK;
                  r.interface_reset = 1'b1;
                  r.reset_interface = index[7:0];
                  r.reset_alternate = value[7:0];
               end else begin
                  r.response = RSP_STALL;
               end
            end else if (recip == RCP_ENDPOINT) begin
               // endpoint number is taken from the whole wIndex
               if (!ep_ok || !(code == REQ_GET_STATUS || code == REQ_CLEAR_FEATURE
                               || code == REQ_SET_FEATURE)) begin
                  r.response = RSP_STALL;
               end else if (code == REQ_GET_STATUS) begin
                  r.response = RSP_DATA;
                  r.reply_length = 2'd2;
                  r.reply_first = {7'd0, halt[index]};
               end else begin
                  halt[index] = (code == REQ_SET_FEATURE);
                  r.response = RSP_ACK;
               end
            end else begin
               r.response = RSP_STALL;
            end
            // refused requests leave nothing for the status stage
            last_req = (r.response == RSP_ACK || r.response == RSP_DATA) ? code : NO_REQUEST;
         end
         default: ;
      endcase
      r.device_address = cur_addr;
      r.active_config = cfg_sel;
      r.configured = (phase == PH_CONFIGURED);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fails++;
      end
   endtask

   // compare results first, then queue the prediction for a new request
   always @(posedge clock) begin
      usb_reply_t exp_r;
      if (reset) begin
         clear_device();
         self_pow = 1'b0;
         ep_count = ENDPOINTS_USED_RST;
         if_count = INTERFACES_USED_RST;
         expected_replies.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen++;
            if (expected_replies.size() == 0) begin
               $error("result with no request waiting, response %0d", rsp_response);
               fails++;
            end else begin
               exp_r = expected_replies.pop_front();
               check_field("response", 16'(exp_r.response), 16'(rsp_response));
               check_field("reply_length", 16'(exp_r.reply_length), 16'(rsp_reply_length));
               check_field("reply_first", 16'(exp_r.reply_first), 16'(rsp_reply_first));
               check_field("reply_second", 16'(exp_r.reply_second), 16'(rsp_reply_second));
               check_field("device_address", 16'(exp_r.device_address),
                           16'(rsp_device_address));
               check_field("active_config", 16'(exp_r.active_config), 16'(rsp_active_config));
               check_field("configured", 16'(exp_r.configured), 16'(rsp_configured));
               check_field("toggles_reset", 16'(exp_r.toggles_reset), 16'(rsp_toggles_reset));
               check_field("interface_reset", 16'(exp_r.interface_reset),
                           16'(rsp_interface_reset));
               check_field("reset_interface", 16'(exp_r.reset_interface),
                           16'(rsp_reset_interface));
               check_field("reset_alternate", 16'(exp_r.reset_alternate),
                           16'(rsp_reset_alternate));
            end
         end
         if (req_valid && !req_stall) begin
            expected_replies.push_back(predict_reply(req_action, req_request_type,
                                                     req_request_code, req_request_value,
                                                     req_request_index));
         end
         // register writes are to happen only while idle; the checker does not enforce this
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SELF_POWERED:    self_pow = csr_write_data[0];
               CSR_ENDPOINTS_USED:  ep_count = csr_write_data[3:0];
               CSR_INTERFACES_USED: if_count = csr_write_data;
               default: ;
            endcase
         end
      end
   end

endmodule

// ----- dv/tb_usb_standard_request_handler.sv -----
// testbench top for the usb standard request handler: clock, reset, requests, verdict
// depends on usr_pkg, usr_reply_checker and the block itself
module tb_usb_standard_request_handler;
   timeunit 1ns;
   timeprecision 1ps;
   import usr_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [7:0] DIR_IN = 8'h80;
   localparam logic [7:0] TYPE_CLASS = 8'h20;
   localparam logic [7:0] TYPE_VENDOR = 8'h40;
   localparam logic [7:0] REQ_UNKNOWN = 8'h0C;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_COUNT = 5;
   localparam int PHASE_REQUESTS = 87;
   localparam logic [7:0] STD_CODES [0:9] = '{REQ_GET_STATUS, REQ_CLEAR_FEATURE,
      REQ_SET_FEATURE, REQ_SET_ADDRESS, REQ_GET_DESC, REQ_GET_CONFIG, REQ_SET_CONFIG,
      REQ_GET_INTERFACE, REQ_SET_INTERFACE, REQ_UNKNOWN};

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = '0;
   logic [7:0]  req_request_type = '0;
   logic [7:0]  req_request_code = '0;
   logic [15:0] req_request_value = '0;
   logic [15:0] req_request_index = '0;
   logic [15:0] req_request_length = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_response;
   logic [1:0]  rsp_reply_length;
   logic [7:0]  rsp_reply_first;
   logic [7:0]  rsp_reply_second;
   logic [6:0]  rsp_device_address;
   logic        rsp_active_config;
   logic        rsp_configured;
   logic        rsp_toggles_reset;
   logic        rsp_interface_reset;
   logic [7:0]  rsp_reset_interface;
   logic [7:0]  rsp_reset_alternate;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_write_data = '0;

   int mismatches;
   int replies_pending;
   int replies_checked;
   int requests_sent = 0;
   int quiet_cycles = 0;
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   bit sender_eager = 1'b0;
   bit receiver_eager = 1'b0;

   usb_standard_request_handler uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_request_type   (req_request_type),
      .req_request_code   (req_request_code),
      .req_request_value  (req_request_value),
      .req_request_index  (req_request_index),
      .req_request_length (req_request_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_response       (rsp_response),
      .rsp_reply_length   (rsp_reply_length),
      .rsp_reply_first    (rsp_reply_first),
      .rsp_reply_second   (rsp_reply_second),
      .rsp_device_address (rsp_device_address),
      .rsp_active_config  (rsp_active_config),
      .rsp_configured     (rsp_configured),
      .rsp_toggles_reset  (rsp_toggles_reset),
      .rsp_interface_reset(rsp_interface_reset),
      .rsp_reset_interface(rsp_reset_interface),
      .rsp_reset_alternate(rsp_reset_alternate),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   usr_reply_checker reply_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_request_type   (req_request_type),
      .req_request_code   (req_request_code),
      .req_request_value  (req_request_value),
      .req_request_index  (req_request_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_response       (rsp_response),
      .rsp_reply_length   (rsp_reply_length),
      .rsp_reply_first    (rsp_reply_first),
      .rsp_reply_second   (rsp_reply_second),
      .rsp_device_address (rsp_device_address),
      .rsp_active_config  (rsp_active_config),
      .rsp_configured     (rsp_configured),
      .rsp_toggles_reset  (rsp_toggles_reset),
      .rsp_interface_reset(rsp_interface_reset),
      .rsp_reset_interface(rsp_reset_interface),
      .rsp_reset_alternate(rsp_reset_alternate),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .mismatches         (mismatches),
      .replies_pending    (replies_pending),
      .replies_checked    (replies_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // handshakes seen at the rising edge, read back at the falling edge
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      rsp_taken <= rsp_valid && !rsp_stall;
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: random stall before each result, with stretches of none
   initial begin
      int hold;
      wait (!reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) receiver_eager = !receiver_eager;
         hold = receiver_eager ? 0 : $urandom_range(0, 13);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(negedge clock); while (!rsp_taken);
      end
   end

   // one request after a random gap; returns at the falling edge after acceptance
   task automatic send_request(input logic [1:0] act, input logic [7:0] rtype,
                               input logic [7:0] code, input logic [15:0] value,
                               input logic [15:0] index, input logic [15:0] length);
      int gap;
      if ($urandom_range(0, 39) == 0) sender_eager = !sender_eager;
      gap = sender_eager ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_action <= act;
      req_request_type <= rtype;
      req_request_code <= code;
      req_request_value <= value;
      req_request_index <= index;
      req_request_length <= length;
      req_valid <= 1'b1;
      do @(negedge clock); while (!req_taken);
      requests_sent++;
   endtask

   // mostly well-formed control traffic, some enumeration runs and some noise
   task automatic send_random_request();
      int pick;
      logic [7:0] rtype;
      logic [7:0] code;
      logic [15:0] value;
      logic [15:0] index;
      pick = $urandom_range(0, 99);
      rtype = 8'($urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) rtype = 8'($urandom_range(3, 15));
      rtype[7] = 1'($urandom_range(0, 1));
      code = ($urandom_range(0, 15) == 0) ? 8'($urandom) : STD_CODES[$urandom_range(0, 9)];
      case ($urandom_range(0, 5))
         0, 1, 2: value = 16'd0;
         3: value = 16'd1;
         4: value = 16'($urandom_range(0, 3));
         default: value = 16'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0: index = 16'($urandom);
         1: index = 16'($urandom_range(250, 257));
         default: index = 16'($urandom_range(0, 9));
      endcase
      if (pick < 3) begin
         send_request(ACT_BUS_RESET, 8'($urandom), 8'($urandom), value, index, 16'($urandom));
      end else if (pick < 9) begin
         // enumeration: address, its status stage, then a configuration
         send_request(ACT_SETUP, 8'h00, REQ_SET_ADDRESS, 16'($urandom), 16'd0, 16'd0);
         send_request(ACT_STATUS, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
         send_request(ACT_SETUP, 8'h00, REQ_SET_CONFIG, 16'($urandom_range(0, 2)), 16'd0,
                      16'd0);
      end else if (pick < 20) begin
         send_request(ACT_STATUS, 8'($urandom), 8'($urandom), value, index, 16'($urandom));
      end else if (pick < 22) begin
         send_request(ACT_UNUSED, 8'($urandom), 8'($urandom), value, index, 16'($urandom));
      end else if (pick < 30) begin
         send_request(2'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
      end else if (pick < 36) begin
         rtype = 8'($urandom);
         if (rtype[6:5] == 2'b00) rtype = rtype | TYPE_CLASS;
         send_request(ACT_SETUP, rtype, code, value, index, 16'($urandom));
      end else begin
         send_request(ACT_SETUP, rtype, code, value, index, 16'($urandom));
         if ($urandom_range(0, 1) == 0) begin
            send_request(ACT_STATUS, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
         end
      end
   endtask

   initial begin
      logic       sp;
      logic [3:0] ep;
      logic [7:0] ifs;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every standard request and the corner cases, reset settings
      send_request(ACT_SETUP, DIR_IN, REQ_GET_STATUS, 16'd0, 16'd0, 16'd2);
      send_request(ACT_SETUP, DIR_IN, REQ_GET_CONFIG, 16'd0, 16'd0, 16'd1);
      send_request(ACT_SETUP, 8'h00, REQ_SET_CONFIG, 16'd1, 16'd0, 16'd0);
      send_request(ACT_SETUP, DIR_IN | RCP_ENDPOINT, REQ_GET_STATUS, 16'd0, 16'd0, 16'd2);
      send_request(ACT_SETUP, TYPE_CLASS | RCP_INTERFACE, 8'hFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF);
      send_request(ACT_SETUP, TYPE_VENDOR, 8'h00, 16'd0, 16'd0, 16'd0);
      send_request(ACT_SETUP, DIR_IN, REQ_GET_DESC, 16'h0100, 16'd0, 16'hFFFF);
      send_request(ACT_STATUS, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
      send_request(ACT_SETUP, 8'h03, REQ_GET_STATUS, 16'd0, 16'd0, 16'd0);
      send_request(ACT_SETUP, 8'h00, REQ_UNKNOWN, 16'd0, 16'd0, 16'd0);
      send_request(ACT_SETUP, 8'h00, REQ_SET_ADDRESS, 16'hFFFF, 16'd0, 16'd0);
      send_request(ACT_STATUS, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
      // a second status stage still finds set address as the last request
      send_request(ACT_STATUS, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(ACT_SETUP, DIR_IN, REQ_GET_CONFIG, 16'd0, 16'd0, 16'd1);
      send_request(ACT_SETUP, RCP_ENDPOINT, REQ_SET_FEATURE, 16'd0, 16'd0, 16'd0);
      send_request(ACT_SETUP, DIR_IN | RCP_ENDPOINT, REQ_GET_STATUS, 16'd0, 16'd0, 16'd2);
      send_request(ACT_SETUP, 8'h00, REQ_SET_CONFIG, 16'd2, 16'd0, 16'd0);
      send_request(ACT_SETUP, 8'h00, REQ_SET_CONFIG, 16'd1, 16'd0, 16'd0);
      send_request(ACT_SETUP, DIR_IN | RCP_INTERFACE, REQ_GET_STATUS, 16'd0, 16'hFFFF, 16'd2);
      send_request(ACT_SETUP, RCP_INTERFACE, REQ_SET_INTERFACE, 16'h00FF, 16'd0, 16'd0);
      send_request(ACT_SETUP, DIR_IN | RCP_INTERFACE, REQ_GET_INTERFACE, 16'd0, 16'd1, 16'd1);
      send_request(ACT_SETUP, RCP_ENDPOINT, REQ_CLEAR_FEATURE, 16'd0, 16'd7, 16'd0);
      send_request(ACT_SETUP, RCP_ENDPOINT, REQ_CLEAR_FEATURE, 16'd0, 16'd8, 16'd0);
      send_request(ACT_SETUP, 8'h00, REQ_SET_ADDRESS, 16'd5, 16'd0, 16'd0);
      send_request(ACT_UNUSED, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
      send_request(ACT_BUS_RESET, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);

      // random phases, each under its own register settings
      for (int s = 0; s < PHASE_COUNT; s++) begin
         req_valid <= 1'b0;
         while (replies_pending != 0) @(negedge clock);
         repeat (4) @(negedge clock);
         case (s)
            0: begin sp = 1'b1; ep = 4'd1; ifs = 8'd1; end
            1: begin sp = 1'b0; ep = 4'd8; ifs = 8'd255; end
            2: begin sp = 1'b1; ep = 4'($urandom_range(1, 8)); ifs = 8'($urandom_range(1, 255)); end
            3: begin sp = 1'b0; ep = 4'($urandom_range(1, 8)); ifs = 8'($urandom_range(1, 4)); end
            default: begin sp = 1'b1; ep = 4'd8; ifs = 8'd2; end
         endcase
         csr_write_enable <= 1'b1;
         csr_index <= CSR_SELF_POWERED;
         csr_write_data <= {7'd0, sp};
         @(negedge clock);
         csr_index <= CSR_ENDPOINTS_USED;
         csr_write_data <= {4'd0, ep};
         @(negedge clock);
         csr_index <= CSR_INTERFACES_USED;
         csr_write_data <= ifs;
         @(negedge clock);
         csr_write_enable <= 1'b0;
         repeat (PHASE_REQUESTS) send_random_request();
      end
      req_valid <= 1'b0;

      // drain and let the pipeline settle
      while (replies_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      $display("tb: %0d requests over %0d register settings, %0d results compared",
               requests_sent, PHASE_COUNT + 1, replies_checked);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
